### rtl/crsf_pkg.sv
// shared constants, scanner state type and crc helper for the crsf frame receiver
// no dependencies
package crsf_pkg;

    localparam int BUFFER_BYTES_DEF  = 64;
    localparam int CHANNEL_COUNT_DEF = 16;
    localparam int CHANNEL_BITS      = 11;
    localparam int QUEUE_DEPTH       = 4;

    localparam logic [7:0] CRC_POLY     = 8'hD5;
    localparam logic [7:0] CHANNELS_LEN = 8'd24;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    typedef enum logic [1:0] {
        REG_RECEIVER_ADDRESS = 2'd0,
        REG_CHANNELS_TYPE    = 2'd1,
        REG_MAX_PAYLOAD      = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_LEN,
        S_RD,
        S_ACC,
        S_PRD,
        S_PACC
    } scan_state_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // crc-8, msb first, no reflection
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++)
        begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

### rtl/crsf_queue.sv
// small byte queue between the frame scanner and the channel unpacker
// depends on crsf_pkg
module crsf_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic [7:0]             push_data,
    input  logic                   pop,
    output logic [7:0]             pop_data,
    output crsf_pkg::queue_status_t status
);
    import crsf_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [7:0]    store_reg [QUEUE_DEPTH];
    logic [PW-1:0] wptr_reg, wptr_next;
    logic [PW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign status.full  = (count_reg == CW'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_data     = store_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wptr_reg] <= push_data;
        end
    end

endmodule

### rtl/crsf_scanner.sv
// front end: byte buffer, length check, crc check and payload forwarding
// depends on crsf_pkg
module crsf_scanner #(
    parameter int BUFFER_BYTES  = crsf_pkg::BUFFER_BYTES_DEF,
    parameter int CHANNEL_COUNT = crsf_pkg::CHANNEL_COUNT_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [7:0]              in_byte,
    input  logic [7:0]              receiver_address,
    input  logic [7:0]              channels_frame_type,
    input  logic [5:0]              max_payload_length,
    output logic                    q_push,
    output logic [7:0]              q_data,
    input  crsf_pkg::queue_status_t q_status
);
    import crsf_pkg::*;

    localparam int PW = $clog2(BUFFER_BYTES);
    localparam int FW = $clog2(BUFFER_BYTES + 1);
    localparam int SW = PW + 9;
    localparam int PAYLOAD_BYTES = (CHANNEL_COUNT * CHANNEL_BITS + 7) / 8;
    localparam logic [7:0] PAYLOAD_LAST = 8'(3 + PAYLOAD_BYTES - 1);

    logic [7:0] mem [BUFFER_BYTES];
    logic [7:0] rdata_reg;

    scan_state_t   state_reg, state_next;
    logic [PW-1:0] head_reg, head_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [7:0]    ofs_reg, ofs_next;
    logic [7:0]    len_reg, len_next;
    logic [7:0]    crc_reg, crc_next;
    logic [7:0]    addr_reg, addr_next;
    logic [7:0]    type_reg, type_next;

    logic [PW-1:0] rd_addr, wr_addr;
    logic [7:0]    rd_ofs;
    logic          wr_en;
    logic          len_bad, len_short, frame_hit;
    logic [8:0]    frame_bytes;

    // position in the circular buffer, offset from the head
    function automatic logic [PW-1:0] wrap(input logic [PW-1:0] base, input logic [8:0] ofs);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(ofs);
        if (sum >= SW'(BUFFER_BYTES))
        begin
            sum = sum - SW'(BUFFER_BYTES);
        end
        return sum[PW-1:0];
    endfunction

    assign in_ready    = (state_reg == S_IDLE);
    assign wr_en       = in_valid && in_ready;
    assign wr_addr     = (fill_reg == FW'(BUFFER_BYTES)) ? head_reg
                                                         : wrap(head_reg, 9'(fill_reg));
    assign rd_ofs      = (state_reg == S_CHECK) ? 8'd1 : ofs_reg;
    assign rd_addr     = wrap(head_reg, {1'b0, rd_ofs});
    assign frame_bytes = {1'b0, rdata_reg} + 9'd2;
    assign len_bad     = (rdata_reg < 8'd3) ||
                         ({1'b0, rdata_reg} > ({3'b0, max_payload_length} + 9'd2));
    assign len_short   = (SW'(fill_reg) < SW'(frame_bytes));
    assign frame_hit   = (addr_reg == receiver_address) &&
                         (type_reg == channels_frame_type) && (len_reg == CHANNELS_LEN);
    assign q_data      = rdata_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = (fill_reg < FW'(2)) ? S_IDLE : S_LEN;
            end
            S_LEN:
            begin
                if (len_bad)
                begin
                    state_next = S_CHECK;
                end
                else if (len_short)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (ofs_reg == len_reg + 8'd1)
                begin
                    if (crc_reg != rdata_reg || !frame_hit)
                    begin
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        state_next = S_PRD;
                    end
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_PRD:
            begin
                if (!q_status.full)
                begin
                    state_next = S_PACC;
                end
            end
            S_PACC:
            begin
                state_next = (ofs_reg == PAYLOAD_LAST) ? S_CHECK : S_PRD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        head_next = head_reg;
        fill_next = fill_reg;
        ofs_next  = ofs_reg;
        len_next  = len_reg;
        crc_next  = crc_reg;
        addr_next = addr_reg;
        type_next = type_reg;
        q_push    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (fill_reg == FW'(BUFFER_BYTES))
                    begin
                        head_next = wrap(head_reg, 9'd1);
                    end
                    else
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                end
            end
            S_LEN:
            begin
                len_next = rdata_reg;
                ofs_next = '0;
                crc_next = '0;
                if (len_bad)
                begin
                    head_next = wrap(head_reg, 9'd1);
                    fill_next = fill_reg - 1'b1;
                end
            end
            S_ACC:
            begin
                ofs_next = ofs_reg + 8'd1;
                if (ofs_reg == 8'd0)
                begin
                    addr_next = rdata_reg;
                end
                if (ofs_reg == 8'd2)
                begin
                    type_next = rdata_reg;
                end
                if (ofs_reg >= 8'd2 && ofs_reg <= len_reg)
                begin
                    crc_next = crc8_update(crc_reg, rdata_reg);
                end
                if (ofs_reg == len_reg + 8'd1)
                begin
                    ofs_next = 8'd3;
                    if (crc_reg != rdata_reg)
                    begin
                        head_next = wrap(head_reg, 9'd1);
                        fill_next = fill_reg - 1'b1;
                    end
                    else if (!frame_hit)
                    begin
                        // good frame that is not a channel frame for this receiver, consume it whole
                        head_next = wrap(head_reg, {1'b0, len_reg} + 9'd2);
                        fill_next = fill_reg - FW'({1'b0, len_reg} + 9'd2);
                    end
                end
            end
            S_PACC:
            begin
                q_push   = 1'b1;
                ofs_next = ofs_reg + 8'd1;
                if (ofs_reg == PAYLOAD_LAST)
                begin
                    head_next = wrap(head_reg, {1'b0, len_reg} + 9'd2);
                    fill_next = fill_reg - FW'({1'b0, len_reg} + 9'd2);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ofs_reg  <= ofs_next;
        len_reg  <= len_next;
        crc_reg  <= crc_next;
        addr_reg <= addr_next;
        type_reg <= type_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= in_byte;
        end
        rdata_reg <= mem[rd_addr];
    end

endmodule

### rtl/crsf_unpacker.sv
// back end: gathers payload bytes into 11-bit channel values with an output register
// depends on crsf_pkg
module crsf_unpacker #(
    parameter int CHANNEL_COUNT = crsf_pkg::CHANNEL_COUNT_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  crsf_pkg::queue_status_t q_status,
    input  logic [7:0]              q_data,
    output logic                    q_pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [3:0]              out_index,
    output logic [10:0]             out_value,
    output logic                    out_last
);
    import crsf_pkg::*;

    logic [18:0] acc_reg, acc_next;
    logic [4:0]  nb_reg, nb_next;
    logic [3:0]  idx_reg, idx_next;
    logic        valid_reg, valid_next;
    logic [3:0]  oidx_reg, oidx_next;
    logic [10:0] oval_reg, oval_next;
    logic        olast_reg, olast_next;
    logic        emit, slot_free, final_ch;

    assign slot_free = !valid_reg || out_ready;
    assign emit      = (nb_reg >= 5'd11) && slot_free;
    assign q_pop     = (nb_reg < 5'd11) && !q_status.empty;
    assign final_ch  = (idx_reg == 4'(CHANNEL_COUNT - 1));

    always_comb
    begin
        acc_next   = acc_reg;
        nb_next    = nb_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg && !out_ready;
        oidx_next  = oidx_reg;
        oval_next  = oval_reg;
        olast_next = olast_reg;
        if (emit)
        begin
            valid_next = 1'b1;
            oidx_next  = idx_reg;
            oval_next  = acc_reg[10:0];
            olast_next = final_ch;
            acc_next   = acc_reg >> 11;
            nb_next    = nb_reg - 5'd11;
            idx_next   = idx_reg + 4'd1;
            if (final_ch)
            begin
                // drop any pad bits left after the last channel
                nb_next  = '0;
                acc_next = '0;
                idx_next = '0;
            end
        end
        else if (q_pop)
        begin
            acc_next = acc_reg | (19'(q_data) << nb_reg);
            nb_next  = nb_reg + 5'd8;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            nb_reg    <= '0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg   <= acc_next;
            nb_reg    <= nb_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        oidx_reg  <= oidx_next;
        oval_reg  <= oval_next;
        olast_reg <= olast_next;
    end

    assign out_valid = valid_reg;
    assign out_index = oidx_reg;
    assign out_value = oval_reg;
    assign out_last  = olast_reg;

    a_nb_range: assert property (@(posedge clk) disable iff (!rst_n) nb_reg <= 5'd18)
        else $error("bit count overflow");
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && final_ch) |=> (nb_reg == 5'd0 && idx_reg == 4'd0))
        else $error("state not cleared after last channel");
    a_no_pop_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
        !(emit && q_pop))
        else $error("pop and emit together");

endmodule

### rtl/crsf_stream_frame_receiver.sv
// crsf frame receiver top level: configuration registers, scanner, queue and unpacker
// depends on crsf_pkg, crsf_scanner, crsf_queue, crsf_unpacker
//
// Takes one received byte per request on the s_ side, buffers it, and rescans the buffer
// for crsf frames (length check, crc-8 poly 0xD5). A good rc channels frame addressed to
// this receiver yields sixteen 11-bit channel requests on the m_ side. Bytes are taken one
// at a time: s_tready stays low while the rescan reads each length byte and checks each
// frame crc through the single read port. A channel frame then forwards its payload bytes
// one by one, waiting while the queue is full under output backpressure. A failed crc
// drops only one byte and the walk restarts further on, so the worst case grows with the
// square of BUFFER_BYTES. Channel output runs independently behind a 4-byte queue and an
// output register.
module crsf_stream_frame_receiver #(
    parameter int BUFFER_BYTES  = crsf_pkg::BUFFER_BYTES_DEF,
    parameter int CHANNEL_COUNT = crsf_pkg::CHANNEL_COUNT_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // rx_byte
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [15:0]                        m_tdata,   // pad, channel_value, channel_index
    output logic                               m_tlast,
    input  logic                               cfg_wr_en,
    input  logic [crsf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [crsf_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import crsf_pkg::*;

    logic [7:0]    rx_addr_reg;
    logic [7:0]    ch_type_reg;
    logic [5:0]    max_pl_reg;
    logic          q_push, q_pop;
    logic [7:0]    q_wdata, q_rdata;
    queue_status_t q_status;
    logic [3:0]    ch_index;
    logic [10:0]   ch_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_addr_reg <= 8'd200;
            ch_type_reg <= 8'd22;
            max_pl_reg  <= 6'd60;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_RECEIVER_ADDRESS: rx_addr_reg <= cfg_wdata;
                REG_CHANNELS_TYPE:    ch_type_reg <= cfg_wdata;
                REG_MAX_PAYLOAD:      max_pl_reg  <= cfg_wdata[5:0];
                default:
                begin
                end
            endcase
        end
    end

    crsf_scanner #(
        .BUFFER_BYTES  (BUFFER_BYTES),
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_scanner (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (s_tvalid),
        .in_ready            (s_tready),
        .in_byte             (s_tdata),
        .receiver_address    (rx_addr_reg),
        .channels_frame_type (ch_type_reg),
        .max_payload_length  (max_pl_reg),
        .q_push              (q_push),
        .q_data              (q_wdata),
        .q_status            (q_status)
    );

    crsf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .status    (q_status)
    );

    crsf_unpacker #(
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_unpacker (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .q_data    (q_rdata),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_index (ch_index),
        .out_value (ch_value),
        .out_last  (m_tlast)
    );

    assign m_tdata = {1'b0, ch_value, ch_index};

endmodule

### tb/testbench.sv
// self-checking testbench for crsf_stream_frame_receiver: byte stream in, channel requests out
// depends on crsf_pkg and the receiver rtl; keeps its own model of buffer, crc and unpacking
module testbench;
    import crsf_pkg::*;

    typedef struct {
        logic [3:0]  index;
        logic [10:0] value;
        logic        last;
    } channel_req_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [7:0] s_tdata = 8'd0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic m_tlast;
    logic cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    crsf_stream_frame_receiver dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // receiver model state
    logic [7:0] rx_buf [0:63];
    int rx_fill = 0;
    logic [7:0] my_addr = 8'd200;
    logic [7:0] chan_type = 8'd22;
    logic [5:0] max_payload = 6'd60;

    logic [7:0] pending_bytes [$];
    channel_req_t expected_channels [$];
    int errors = 0;
    int sender_gap = 0;
    int sender_idle_max = 19;
    int recv_stall = 0;
    int recv_idle_max = 19;
    int hold_requests = 0;
    int holds_done = 0;
    int hold_left = 0;

    initial forever #1 clk = ~clk;

    function automatic logic [7:0] crc_step(logic [7:0] crc, logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++)
            c = c[7] ? ((c << 1) ^ 8'hD5) : (c << 1);
        return c;
    endfunction

    task automatic drop_bytes(int n);
        if (n >= rx_fill)
        begin
            rx_fill = 0;
        end
        else
        begin
            for (int i = 0; i < rx_fill - n; i++)
                rx_buf[i] = rx_buf[i + n];
            rx_fill = rx_fill - n;
        end
    endtask

    // append one byte and rescan, queueing every channel the byte releases
    task automatic take_byte(logic [7:0] b);
        int len;
        int produced;
        logic [7:0] crc;
        logic [23:0] w;
        int bitpos;
        produced = 0;
        if (rx_fill >= 64)
            drop_bytes(1);
        rx_buf[rx_fill] = b;
        rx_fill++;
        forever
        begin
            if (rx_fill < 2)
                break;
            len = rx_buf[1];
            if (len < 3 || len > int'(max_payload) + 2)
            begin
                drop_bytes(1);
                continue;
            end
            if (rx_fill < len + 2)
                break;
            crc = 8'd0;
            for (int i = 0; i + 1 < len; i++)
                crc = crc_step(crc, rx_buf[2 + i]);
            if (crc != rx_buf[len + 1])
            begin
                drop_bytes(1);
                continue;
            end
            if (rx_buf[0] == my_addr && rx_buf[2] == chan_type && len == 24)
            begin
                for (int ch = 0; ch < 16 && produced < 32; ch++)
                begin
                    bitpos = ch * 11;
                    w = 24'd0;
                    for (int k = 0; k < 3; k++)
                        if ((bitpos >> 3) + k < 22)
                            w[k*8 +: 8] = rx_buf[3 + (bitpos >> 3) + k];
                    expected_channels.push_back('{ch[3:0], w[(bitpos & 7) +: 11], ch == 15});
                    produced++;
                end
            end
            drop_bytes(len + 2);
        end
    endtask

    // sender
    always @(posedge clk)
    begin
        logic next_valid;
        int g;
        if (rst_n)
        begin
            next_valid = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                take_byte(s_tdata);
                g = $urandom_range(0, sender_idle_max);
                next_valid = 1'b0;
                if (g == 0 && pending_bytes.size() > 0)
                begin
                    s_tdata <= pending_bytes.pop_front();
                    next_valid = 1'b1;
                end
                sender_gap <= g;
            end
            else if (!s_tvalid)
            begin
                if (sender_gap > 0)
                    sender_gap <= sender_gap - 1;
                else if (pending_bytes.size() > 0)
                begin
                    s_tdata <= pending_bytes.pop_front();
                    next_valid = 1'b1;
                end
            end
            s_tvalid <= next_valid;
        end
    end

    // receiver and checker
    always @(posedge clk)
    begin
        channel_req_t e;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_channels.size() == 0)
                begin
                    $display("%0t: unexpected channel request tdata=%h tlast=%b",
                             $time, m_tdata, m_tlast);
                    errors++;
                end
                else
                begin
                    e = expected_channels.pop_front();
                    if (m_tdata[3:0] !== e.index)
                    begin
                        $display("%0t: channel_index expected %0d got %0d",
                                 $time, e.index, m_tdata[3:0]);
                        errors++;
                    end
                    if (m_tdata[14:4] !== e.value)
                    begin
                        $display("%0t: channel_value expected %0d got %0d",
                                 $time, e.value, m_tdata[14:4]);
                        errors++;
                    end
                    if (m_tlast !== e.last)
                    begin
                        $display("%0t: last_channel expected %b got %b",
                                 $time, e.last, m_tlast);
                        errors++;
                    end
                end
                recv_stall = $urandom_range(0, recv_idle_max);
            end
            if (holds_done != hold_requests)
            begin
                holds_done = hold_requests;
                hold_left = 600;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (recv_stall > 0)
            begin
                recv_stall--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic queue_frame(logic [7:0] addr, logic [7:0] ftype, int len,
                               int fill_mode, bit corrupt);
        logic [7:0] crc;
        logic [7:0] b;
        crc = crc_step(8'd0, ftype);
        pending_bytes.push_back(addr);
        pending_bytes.push_back(len[7:0]);
        pending_bytes.push_back(ftype);
        for (int i = 0; i < len - 2; i++)
        begin
            b = (fill_mode == 0) ? 8'h00 : (fill_mode == 1) ? 8'hFF : 8'($urandom);
            crc = crc_step(crc, b);
            pending_bytes.push_back(b);
        end
        if (corrupt)
            crc = crc ^ (8'd1 << $urandom_range(0, 7));
        pending_bytes.push_back(crc);
    endtask

    task automatic write_reg(cfg_reg_t r, logic [7:0] v);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= r;
        cfg_wdata <= v;
        case (r)
            REG_RECEIVER_ADDRESS: my_addr = v;
            REG_CHANNELS_TYPE:    chan_type = v;
            default:              max_payload = v[5:0];
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // waits until the sender has nothing left, the block has delivered everything and the scanner is idle again
    task automatic settle;
        while (pending_bytes.size() > 0 || s_tvalid || expected_channels.size() > 0 ||
               !s_tready)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic random_traffic(int nbytes);
        int start;
        int pick;
        start = pending_bytes.size();
        while (pending_bytes.size() - start < nbytes)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                queue_frame(my_addr, chan_type, 24, 2, 1'b0);
            else if (pick < 72)
                queue_frame(8'($urandom), 8'($urandom), $urandom_range(3, 12), 2, 1'b0);
            else if (pick < 84)
                queue_frame(my_addr, chan_type, 24, 2, 1'b1);
            else
                repeat ($urandom_range(1, 5)) pending_bytes.push_back(8'($urandom));
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        // defaults after reset
        queue_frame(8'd200, 8'd22, 24, 1, 1'b0);
        queue_frame(8'd201, 8'd22, 24, 2, 1'b0);   // wrong address
        queue_frame(8'd200, 8'd22, 5, 2, 1'b1);    // bad crc
        queue_frame(8'd200, 8'd22, 5, 2, 1'b0);    // good crc, wrong length
        pending_bytes.push_back(8'd200);
        pending_bytes.push_back(8'd2);             // length below range
        pending_bytes.push_back(8'd200);
        pending_bytes.push_back(8'd255);           // length above range
        settle();

        // back to back with the output held off
        hold_requests = 1;
        sender_idle_max = 0;
        recv_idle_max = 0;
        queue_frame(8'd200, 8'd22, 24, 2, 1'b0);
        random_traffic(20);
        settle();

        write_reg(REG_RECEIVER_ADDRESS, 8'd0);
        write_reg(REG_CHANNELS_TYPE, 8'd0);
        write_reg(REG_MAX_PAYLOAD, 8'd22);
        sender_idle_max = 19;
        recv_idle_max = 19;
        queue_frame(8'd0, 8'd0, 24, 0, 1'b0);
        settle();

        write_reg(REG_RECEIVER_ADDRESS, 8'd255);
        write_reg(REG_CHANNELS_TYPE, 8'd255);
        write_reg(REG_MAX_PAYLOAD, 8'd1);
        queue_frame(8'd255, 8'd255, 3, 2, 1'b0);
        queue_frame(8'd255, 8'd255, 4, 2, 1'b0);   // rejected by length check
        settle();

        write_reg(REG_RECEIVER_ADDRESS, 8'($urandom));
        write_reg(REG_CHANNELS_TYPE, 8'($urandom));
        write_reg(REG_MAX_PAYLOAD, 8'd63);
        sender_idle_max = 5;
        pending_bytes.push_back(8'd7);
        pending_bytes.push_back(8'd65);            // frame longer than buffer
        repeat (64) pending_bytes.push_back(8'($urandom));
        settle();

        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial
    begin
        #10000000;
        $display("testbench: errors");
        $finish;
    end
endmodule
